@@ rtl/ptpp_pkg.sv @@
// Shared types, constants and helpers for the point-to-pixel projection block.
// No dependencies; every other file imports this package.
package ptpp_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 4;
    localparam int QUO_BITS       = 12;
    localparam int SIZE_BITS      = 13;
    localparam int PARAM_BITS     = 16;
    localparam int CFG_IDX_BITS   = 3;
    localparam int MAX_SIZE       = 4096;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FOCAL_X  = 3'd0,
        CFG_FOCAL_Y  = 3'd1,
        CFG_CENTER_X = 3'd2,
        CFG_CENTER_Y = 3'd3,
        CFG_WIDTH    = 3'd4,
        CFG_HEIGHT   = 3'd5
    } t_cfg_idx;

    localparam logic [PARAM_BITS-1:0] RST_FOCAL_X  = 16'd7369;
    localparam logic [PARAM_BITS-1:0] RST_FOCAL_Y  = 16'd7364;
    localparam logic [PARAM_BITS-1:0] RST_CENTER_X = 16'd5345;
    localparam logic [PARAM_BITS-1:0] RST_CENTER_Y = 16'd2717;
    localparam logic [SIZE_BITS-1:0]  RST_WIDTH    = 13'd640;
    localparam logic [SIZE_BITS-1:0]  RST_HEIGHT   = 13'd360;

    // Data that rides along the pipeline next to the divider cells.
    typedef struct packed {
        logic       valid;
        logic       zero;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_side;

    // Largest legal index for an image size; zero acts as one, big sizes saturate.
    function automatic logic [QUO_BITS-1:0] size_limit(input logic [SIZE_BITS-1:0] size);
        logic [SIZE_BITS-1:0] dec;
        begin
            dec = size - 13'd1;
            if (size == '0) begin
                size_limit = '0;
            end else if (size >= SIZE_BITS'(MAX_SIZE)) begin
                size_limit = '1;
            end else begin
                size_limit = dec[QUO_BITS-1:0];
            end
        end
    endfunction

endpackage

@@ rtl/point_to_pixel_projection.sv @@
// Pinhole projection of a colored 3D point to a pixel write address and color.
// Input points enter on i_in_valid/o_in_ready, results leave on o_out_valid/i_out_ready.
// Configuration uses i_cfg_valid/o_cfg_ready with a register index and 16-bit data;
// registers 0..5 are focal_x, focal_y, center_x, center_y, image_width, image_height.
// Write configuration only while no point is in flight.
// From input transfer to result on the output register a point passes two
// multiply/add stages, thirteen divider cells (one saturation check and twelve
// quotient bits, one bit per cell) and the output stage. Throughput is one point
// per cycle unless the receiver stalls; every cell works on a different point each cycle.
// When the receiver stalls with a result waiting, the whole chain holds and o_in_ready
// drops; it rises again in the cycle the result is taken.
// Reset clears all valid bits and loads the default camera setup (640x360 image).
// A point with zero depth still yields one result, with write_valid and all fields zero.
// Column and row are |trunc(num/den)| clamped to size-1.
module point_to_pixel_projection
    import ptpp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_BITS-1:0]  i_point_x,
    input  logic signed [COORD_BITS-1:0]  i_point_y,
    input  logic [COORD_BITS-1:0]         i_point_z,
    input  logic [7:0]                    i_in_red,
    input  logic [7:0]                    i_in_green,
    input  logic [7:0]                    i_in_blue,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [QUO_BITS-1:0]           o_pixel_column,
    output logic [QUO_BITS-1:0]           o_pixel_row,
    output logic [7:0]                    o_out_red,
    output logic [7:0]                    o_out_green,
    output logic [7:0]                    o_out_blue,
    output logic                          o_write_valid,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [PARAM_BITS-1:0]         i_cfg_data
);
    localparam int PW = COORD_BITS + PARAM_BITS + 1;  // signed coord * focal
    localparam int CW = COORD_BITS + PARAM_BITS;      // center * depth
    localparam int NW = COORD_BITS + PARAM_BITS + 2;  // signed numerator
    localparam int MW = NW - 1;                       // numerator magnitude
    localparam int DW = COORD_BITS + FRAC_BITS;       // scaled depth
    localparam int NC = QUO_BITS + 1;                 // divider cells

    logic [PARAM_BITS-1:0] r_focal_x, r_focal_y, r_center_x, r_center_y;
    logic [SIZE_BITS-1:0]  r_width, r_height;
    logic                  en;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= RST_FOCAL_X;
            r_focal_y  <= RST_FOCAL_Y;
            r_center_x <= RST_CENTER_X;
            r_center_y <= RST_CENTER_Y;
            r_width    <= RST_WIDTH;
            r_height   <= RST_HEIGHT;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FOCAL_X:  r_focal_x  <= i_cfg_data;
                CFG_FOCAL_Y:  r_focal_y  <= i_cfg_data;
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                CFG_WIDTH:    r_width    <= i_cfg_data[SIZE_BITS-1:0];
                CFG_HEIGHT:   r_height   <= i_cfg_data[SIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic r_out_valid;
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Stage 1: products.
    logic signed [PW-1:0] r_px, r_py;
    logic [CW-1:0]        r_cx, r_cy;
    logic [DW-1:0]        r_den1;
    t_side                r_side1;
    t_side                n_side1;

    always_comb begin
        n_side1.valid = i_in_valid;
        n_side1.zero  = (i_point_z == '0);
        n_side1.red   = i_in_red;
        n_side1.green = i_in_green;
        n_side1.blue  = i_in_blue;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px   <= PW'(i_point_x) * PW'($signed({1'b0, r_focal_x}));
            r_py   <= PW'(i_point_y) * PW'($signed({1'b0, r_focal_y}));
            r_cx   <= CW'(r_center_x) * CW'(i_point_z);
            r_cy   <= CW'(r_center_y) * CW'(i_point_z);
            r_den1 <= DW'(i_point_z) << FRAC_BITS;
        end
    end

    // Stage 2: numerator sum and magnitude.
    logic signed [NW-1:0] num_x, num_y;
    logic [MW-1:0]        r_mag_x, r_mag_y;
    logic [DW-1:0]        r_den2;
    t_side                r_side2;

    always_comb begin
        num_x = NW'(r_px) + $signed(NW'(r_cx));
        num_y = NW'(r_py) + $signed(NW'(r_cy));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag_x <= num_x[NW-1] ? MW'(-num_x) : MW'(num_x);
            r_mag_y <= num_y[NW-1] ? MW'(-num_y) : MW'(num_y);
            r_den2  <= r_den1;
        end
    end

    // Divider cell chains, one per axis; the first cell of each checks saturation.
    logic [MW-1:0]     rem_x [NC+1];
    logic [MW-1:0]     rem_y [NC+1];
    logic [DW-1:0]     den_x [NC+1];
    logic [DW-1:0]     den_y [NC+1];
    logic [QUO_BITS:0] quo_x [NC+1];
    logic [QUO_BITS:0] quo_y [NC+1];
    t_side             r_side [NC];

    assign rem_x[0] = r_mag_x;
    assign rem_y[0] = r_mag_y;
    assign den_x[0] = r_den2;
    assign den_y[0] = r_den2;
    assign quo_x[0] = '0;
    assign quo_y[0] = '0;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        ptpp_div_cell #(.MW(MW), .DW(DW), .SHIFT(QUO_BITS - k)) u_cell_x (
            .i_clk(i_clk), .i_en(en),
            .i_rem(rem_x[k]), .i_den(den_x[k]), .i_quo(quo_x[k]),
            .o_rem(rem_x[k+1]), .o_den(den_x[k+1]), .o_quo(quo_x[k+1])
        );
        ptpp_div_cell #(.MW(MW), .DW(DW), .SHIFT(QUO_BITS - k)) u_cell_y (
            .i_clk(i_clk), .i_en(en),
            .i_rem(rem_y[k]), .i_den(den_y[k]), .i_quo(quo_y[k]),
            .o_rem(rem_y[k+1]), .o_den(den_y[k+1]), .o_quo(quo_y[k+1])
        );
    end

    // Side data and valid bits march with the cells; only the valid bits are reset.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side1.zero  <= n_side1.zero;
            r_side1.red   <= n_side1.red;
            r_side1.green <= n_side1.green;
            r_side1.blue  <= n_side1.blue;
            r_side2.zero  <= r_side1.zero;
            r_side2.red   <= r_side1.red;
            r_side2.green <= r_side1.green;
            r_side2.blue  <= r_side1.blue;
            r_side[0].zero  <= r_side2.zero;
            r_side[0].red   <= r_side2.red;
            r_side[0].green <= r_side2.green;
            r_side[0].blue  <= r_side2.blue;
            for (int k = 1; k < NC; k++) begin
                r_side[k].zero  <= r_side[k-1].zero;
                r_side[k].red   <= r_side[k-1].red;
                r_side[k].green <= r_side[k-1].green;
                r_side[k].blue  <= r_side[k-1].blue;
            end
        end
        if (!i_rst_n) begin
            r_side1.valid <= 1'b0;
            r_side2.valid <= 1'b0;
            for (int k = 0; k < NC; k++) begin
                r_side[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_side1.valid <= n_side1.valid;
            r_side2.valid <= r_side1.valid;
            r_side[0].valid <= r_side2.valid;
            for (int k = 1; k < NC; k++) begin
                r_side[k].valid <= r_side[k-1].valid;
            end
        end
    end

    // Output stage: saturate, clamp to the image, blank zero-depth points.
    logic [QUO_BITS-1:0] lim_x, lim_y, q_x, q_y;
    logic [QUO_BITS-1:0] r_col, r_row;
    logic [7:0]          r_red, r_green, r_blue;
    logic                r_wv;
    t_side               last;

    always_comb begin
        last  = r_side[NC-1];
        lim_x = size_limit(r_width);
        lim_y = size_limit(r_height);
        q_x   = quo_x[NC][QUO_BITS] ? '1 : quo_x[NC][QUO_BITS-1:0];
        q_y   = quo_y[NC][QUO_BITS] ? '1 : quo_y[NC][QUO_BITS-1:0];
        if (q_x > lim_x) q_x = lim_x;
        if (q_y > lim_y) q_y = lim_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_col   <= last.zero ? '0 : q_x;
            r_row   <= last.zero ? '0 : q_y;
            r_red   <= last.zero ? '0 : last.red;
            r_green <= last.zero ? '0 : last.green;
            r_blue  <= last.zero ? '0 : last.blue;
            r_wv    <= !last.zero;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_column = r_col;
    assign o_pixel_row    = r_row;
    assign o_out_red      = r_red;
    assign o_out_green    = r_green;
    assign o_out_blue     = r_blue;
    assign o_write_valid  = r_wv;

    a_col_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_write_valid |-> o_pixel_column <= lim_x && o_pixel_row <= lim_y)
        else $error("pixel address outside the image");

    a_blank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_write_valid |-> o_pixel_column == '0 && o_out_red == '0)
        else $error("zero-depth result not blanked");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_side[NC-1]) && $stable(quo_x[NC]))
        else $error("chain moved during a stall");
endmodule

@@ rtl/ptpp_div_cell.sv @@
// One cell of the restoring divider chain: tries one shifted divisor, keeps the remainder.
// Depends on ptpp_pkg.
module ptpp_div_cell
    import ptpp_pkg::*;
#(
    parameter int MW    = 33,
    parameter int DW    = 20,
    parameter int SHIFT = 0
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [MW-1:0]       i_rem,
    input  logic [DW-1:0]       i_den,
    input  logic [QUO_BITS:0]   i_quo,
    output logic [MW-1:0]       o_rem,
    output logic [DW-1:0]       o_den,
    output logic [QUO_BITS:0]   o_quo
);
    localparam int CW = (MW > DW + SHIFT) ? MW : DW + SHIFT;

    logic [CW-1:0]     rem_ext;
    logic [CW-1:0]     trial;
    logic [CW-1:0]     diff;
    logic              ge;
    logic [MW-1:0]     n_rem;
    logic [QUO_BITS:0] n_quo;
    logic [MW-1:0]     r_rem;
    logic [DW-1:0]     r_den;
    logic [QUO_BITS:0] r_quo;

    always_comb begin
        rem_ext = CW'(i_rem);
        trial   = CW'(i_den) << SHIFT;
        diff    = rem_ext - trial;
        ge      = rem_ext >= trial;
        n_rem   = ge ? diff[MW-1:0] : i_rem;
        n_quo   = i_quo;
        n_quo[SHIFT] = ge;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_quo <= n_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;
endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for point_to_pixel_projection: random and corner points,
// several camera setups and handshake stall patterns. Depends on rtl/ptpp_pkg.sv.
module testbench;
    import ptpp_pkg::*;

    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        wr;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [15:0] i_point_x = '0;
    logic signed [15:0] i_point_y = '0;
    logic [15:0] i_point_z = '0;
    logic [7:0] i_in_red = '0, i_in_green = '0, i_in_blue = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [11:0] o_pixel_column, o_pixel_row;
    logic [7:0] o_out_red, o_out_green, o_out_blue;
    logic o_write_valid;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    // Camera setup as the predictor sees it.
    logic [15:0] cam_fx, cam_fy, cam_cx, cam_cy;
    logic [12:0] cam_w, cam_h;

    t_pixel pixel_queue[$];
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    always #6 i_clk = ~i_clk;

    point_to_pixel_projection dut (.*);

    function automatic logic [11:0] project_axis(input logic signed [15:0] p,
            input logic [15:0] z, input logic [15:0] focal, input logic [15:0] center,
            input logic [12:0] size);
        longint num, den, q, lim;
        num = longint'(p) * longint'(focal) + longint'(center) * longint'(z);
        den = longint'(z) * 16;
        q = num / den;
        lim = (size == 0) ? 0 : (size > 4096) ? 4095 : longint'(size) - 1;
        if (q < 0) q = -q;
        if (q > lim) q = lim;
        return q[11:0];
    endfunction

    function automatic t_pixel project_point(input logic signed [15:0] x,
            input logic signed [15:0] y, input logic [15:0] z,
            input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        t_pixel px;
        px = '0;
        if (z != 0) begin
            px.column = project_axis(x, z, cam_fx, cam_cx, cam_w);
            px.row = project_axis(y, z, cam_fy, cam_cy, cam_h);
            px.red = r;
            px.green = g;
            px.blue = b;
            px.wr = 1'b1;
        end
        return px;
    endfunction

    // Valid stays high across back-to-back transfers; it drops only while idling.
    task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
            input logic [15:0] z, input logic [7:0] r, input logic [7:0] g,
            input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        i_point_z <= z;
        i_in_red <= r;
        i_in_green <= g;
        i_in_blue <= b;
        do @(posedge i_clk); while (!o_in_ready);
        pixel_queue.push_back(project_point(x, y, z, r, g, b));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FOCAL_X:  cam_fx = value;
            CFG_FOCAL_Y:  cam_fy = value;
            CFG_CENTER_X: cam_cx = value;
            CFG_CENTER_Y: cam_cy = value;
            CFG_WIDTH:    cam_w = value[12:0];
            CFG_HEIGHT:   cam_h = value[12:0];
            default: ;
        endcase
    endtask

    task automatic set_camera(input logic [15:0] fx, input logic [15:0] fy,
            input logic [15:0] cx, input logic [15:0] cy, input logic [12:0] w,
            input logic [12:0] h);
        wait_drained();
        write_reg(CFG_FOCAL_X, fx);
        write_reg(CFG_FOCAL_Y, fy);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_WIDTH, 16'(w));
        write_reg(CFG_HEIGHT, 16'(h));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_point();
        logic [15:0] z;
        case ($urandom_range(3))
            0: z = 16'($urandom_range(1, 16));
            1: z = 16'($urandom_range(1, 4000));
            2: z = 16'($urandom());
            default: z = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(200, 9000));
        endcase
        send_point(16'($urandom()), 16'($urandom()), z, 8'($urandom()), 8'($urandom()),
                   8'($urandom()));
    endtask

    task automatic test_corners();
        send_point(16'sh7FFF, 16'sh7FFF, 16'd1, 8'hFF, 8'hFF, 8'hFF);
        send_point(-16'sd32768, -16'sd32768, 16'd1, 8'h00, 8'h00, 8'h00);
        send_point(16'sd0, 16'sd0, 16'hFFFF, 8'hA5, 8'h5A, 8'h3C);
        send_point(16'sd100, -16'sd100, 16'd0, 8'hFF, 8'h80, 8'h01);
        send_point(-16'sd1, 16'sd1, 16'd1000, 8'h12, 8'h34, 8'h56);
        send_point(-16'sd2000, -16'sd800, 16'd1000, 8'h01, 8'h02, 8'h04);
        send_point(16'sd700, 16'sd300, 16'd1000, 8'h08, 8'h10, 8'h20);
        send_point(16'sh7FFF, -16'sd32768, 16'hFFFF, 8'h40, 8'h80, 8'hFF);
    endtask

    task automatic test_camera_extremes();
        // Zero focal length puts every point on the principal point; large centers clamp.
        set_camera(16'd0, 16'd0, 16'hFFFF, 16'd0, 13'd4096, 13'd1);
        repeat (6) send_random_point();
        set_camera(16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 13'd1, 13'd4096);
        repeat (6) send_random_point();
        // Out-of-range sizes: zero acts as one, above 4096 saturates.
        set_camera(16'd1, 16'hFFFF, 16'd8000, 16'd8000, 13'd0, 13'h1FFF);
        repeat (6) send_random_point();
    endtask

    task automatic test_random(input int count);
        repeat (count) send_random_point();
    endtask

    task automatic test_pause_until_empty();
        repeat (20) send_random_point();
        i_in_valid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (20) send_random_point();
    endtask

    // Receiver: random stall, then compare each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_pixel got, want;
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_pixel_column, o_pixel_row, o_out_red, o_out_green, o_out_blue,
                   o_write_valid};
            if (pixel_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result %h", got);
            end else begin
                want = pixel_queue.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: col %0d/%0d row %0d/%0d rgb %h%h%h/%h%h%h wr %b/%b",
                            want.column, got.column, want.row, got.row,
                            want.red, want.green, want.blue, got.red, got.green, got.blue,
                            want.wr, got.wr);
                end
            end
        end
    end

    initial begin
        cam_fx = RST_FOCAL_X;
        cam_fy = RST_FOCAL_Y;
        cam_cx = RST_CENTER_X;
        cam_cy = RST_CENTER_Y;
        cam_w = RST_WIDTH;
        cam_h = RST_HEIGHT;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 24;
        recv_idle_pct = 82;
        test_corners();
        test_random(450);
        test_pause_until_empty();
        test_camera_extremes();
        set_camera(16'd3000, 16'd9000, 16'd2000, 16'd30000, 13'd1920, 13'd1080);
        send_idle_pct = 82;
        recv_idle_pct = 24;
        test_random(500);
        set_camera(16'd65535, 16'd65535, 16'd65535, 16'd65535, 13'd4096, 13'd4096);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(300);
        set_camera(RST_FOCAL_X, RST_FOCAL_Y, RST_CENTER_X, RST_CENTER_Y, 13'd640, 13'd360);
        test_random(300);
        wait_drained();

        if (mismatch_count == 0 && pixel_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
